// ===== rtl/core/dda_pkg.sv =====
// ----------------------------------------------------------------------------
// dda_pkg
// Shared types and constants of the dda line rasterizer.
// ----------------------------------------------------------------------------
package dda_pkg;

  localparam int unsigned COORD_W        = 6;   // field width of every coordinate
  localparam int unsigned COORD_BITS_DEF = 6;   // default of the active coordinate bits
  localparam int unsigned FRAC_BITS      = 16;  // fraction bits of increments
  localparam int unsigned INC_W          = FRAC_BITS + 2;            // signed increment
  localparam int unsigned ACC_W          = COORD_W + FRAC_BITS + 2;  // signed accumulator
  localparam int unsigned CMD_DEPTH      = 2;

  typedef struct packed {
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
  } seg_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic               last;
  } pix_t;

  // one prepared segment handed from front to back
  typedef struct packed {
    logic [COORD_W-1:0]      xs;
    logic [COORD_W-1:0]      ys;
    logic signed [INC_W-1:0] inc_x;
    logic signed [INC_W-1:0] inc_y;
    logic [COORD_W-1:0]      steps;
  } cmd_t;

  typedef enum logic [1:0] {
    FrIdle,
    FrDivX,
    FrDivY,
    FrPush
  } front_state_e;

endpackage

// ===== rtl/core/dda_div.sv =====
// ----------------------------------------------------------------------------
// dda_div
// Restoring divider, one quotient bit per cycle: (num << FRAC_BITS) / den.
// ----------------------------------------------------------------------------
module dda_div import dda_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [COORD_BITS-1:0]           num_i,
  input  logic [COORD_BITS-1:0]           den_i,
  output logic                            done_o,
  output logic [COORD_BITS+FRAC_BITS-1:0] quot_o
);

  localparam int unsigned N  = COORD_BITS + FRAC_BITS;
  localparam int unsigned CW = $clog2(N + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [N-1:0]  num_q;
  logic [COORD_BITS-1:0] rem_q;
  logic [COORD_BITS-1:0] den_q;

  logic [COORD_BITS:0] rem_sh;
  logic [COORD_BITS:0] rem_diff;
  logic                ge;

  assign rem_sh   = {rem_q, num_q[N-1]};
  assign ge       = rem_sh >= {1'b0, den_q};
  assign rem_diff = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(N);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - CW'(1);
      done_q <= (cnt_q == CW'(1));
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // quotient bits shift in where the dividend bits shift out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {num_i, FRAC_BITS'(0)};
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      num_q <= {num_q[N-2:0], ge};
      rem_q <= ge ? rem_diff[COORD_BITS-1:0] : rem_sh[COORD_BITS-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

// ===== rtl/core/dda_front.sv =====
// ----------------------------------------------------------------------------
// dda_front
// Takes a segment, finds step count and both signed axis increments.
// ----------------------------------------------------------------------------
module dda_front import dda_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  seg_t seg_i,
  input  logic push,
  output logic full,
  output cmd_t cmd_o,
  output logic cmd_push_o,
  input  logic cmd_full_i
);

  localparam int unsigned QW = COORD_BITS + FRAC_BITS;
  localparam logic [COORD_W-1:0] Mask = COORD_W'((1 << COORD_BITS) - 1);

  front_state_e state_q, state_d;

  logic [COORD_W-1:0] xs, ys, xe, ye;
  logic [COORD_W:0]   dx, dy;
  logic [COORD_W-1:0] adx, ady, steps;
  logic               accept;

  logic [COORD_W-1:0]      xs_q, ys_q, steps_q, ady_q;
  logic                    xneg_q, yneg_q;
  logic signed [INC_W-1:0] incx_q, incy_q;

  logic                  div_start;
  logic [COORD_BITS-1:0] div_num, div_den;
  logic                  div_done;
  logic [QW-1:0]         div_quot;

  function automatic logic signed [INC_W-1:0] signed_inc(input logic [QW-1:0] q,
                                                         input logic neg);
    logic signed [INC_W-1:0] mag;
    mag = $signed({1'b0, q[FRAC_BITS:0]});
    return neg ? -mag : mag;
  endfunction

  assign xs = seg_i.x_start & Mask;
  assign ys = seg_i.y_start & Mask;
  assign xe = seg_i.x_end & Mask;
  assign ye = seg_i.y_end & Mask;
  assign dx = {1'b0, xe} - {1'b0, xs};
  assign dy = {1'b0, ye} - {1'b0, ys};
  assign adx = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
  assign ady = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
  assign steps = (adx > ady) ? adx : ady;

  assign full   = (state_q != FrIdle);
  assign accept = push && (state_q == FrIdle);

  dda_div #(
    .COORD_BITS(COORD_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_comb begin
    state_d    = state_q;
    div_start  = 1'b0;
    div_num    = adx[COORD_BITS-1:0];
    div_den    = steps[COORD_BITS-1:0];
    cmd_push_o = 1'b0;
    case (state_q)
      FrIdle: begin
        if (accept) begin
          // a zero-length segment needs no increments
          if (steps == '0) begin
            state_d = FrPush;
          end else begin
            div_start = 1'b1;
            state_d   = FrDivX;
          end
        end
      end
      FrDivX: begin
        div_num = ady_q[COORD_BITS-1:0];
        div_den = steps_q[COORD_BITS-1:0];
        if (div_done) begin
          div_start = 1'b1;
          state_d   = FrDivY;
        end
      end
      FrDivY: begin
        if (div_done) begin
          state_d = FrPush;
        end
      end
      FrPush: begin
        cmd_push_o = 1'b1;
        if (!cmd_full_i) begin
          state_d = FrIdle;
        end
      end
      default: state_d = FrIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      xs_q    <= xs;
      ys_q    <= ys;
      steps_q <= steps;
      ady_q   <= ady;
      xneg_q  <= dx[COORD_W];
      yneg_q  <= dy[COORD_W];
      incx_q  <= '0;
      incy_q  <= '0;
    end else if (div_done && state_q == FrDivX) begin
      incx_q <= signed_inc(div_quot, xneg_q);
    end else if (div_done && state_q == FrDivY) begin
      incy_q <= signed_inc(div_quot, yneg_q);
    end
  end

  assign cmd_o.xs    = xs_q;
  assign cmd_o.ys    = ys_q;
  assign cmd_o.inc_x = incx_q;
  assign cmd_o.inc_y = incy_q;
  assign cmd_o.steps = steps_q;

endmodule

// ===== rtl/core/dda_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// dda_cmd_fifo
// Short queue of prepared segments between front and back.
// ----------------------------------------------------------------------------
module dda_cmd_fifo import dda_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t wdata_i,
  input  logic push_i,
  output logic full_o,
  output cmd_t rdata_o,
  input  logic pop_i,
  output logic empty_o
);

  localparam int unsigned PW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int unsigned NW = $clog2(CMD_DEPTH + 1);

  cmd_t          mem_q [CMD_DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [NW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == NW'(CMD_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    return (p == PW'(CMD_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= next_ptr(wptr_q);
      end
      if (do_pop) begin
        rptr_q <= next_ptr(rptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + NW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/core/dda_back.sv =====
// ----------------------------------------------------------------------------
// dda_back
// Walks a segment: one rounded pixel per cycle into the result register when free.
// ----------------------------------------------------------------------------
module dda_back import dda_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  logic cmd_empty_i,
  output logic cmd_pop_o,
  output pix_t pix_o,
  output logic empty,
  input  logic pop
);

  localparam logic [COORD_W-1:0] MaxCoord = COORD_W'((1 << COORD_BITS) - 1);
  localparam int unsigned RW = ACC_W - FRAC_BITS;

  logic                    busy_q;
  logic [COORD_W-1:0]      k_q, steps_q;
  logic signed [ACC_W-1:0] accx_q, accy_q;
  logic signed [INC_W-1:0] incx_q, incy_q;
  logic                    out_valid_q;
  pix_t                    out_q;

  logic load, adv, last;

  // half away from zero, clamped to the coordinate range
  function automatic logic [COORD_W-1:0] round_coord(input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-1:0] sum;
    logic [RW-1:0]    r;
    sum = acc + ACC_W'(1 << (FRAC_BITS - 1));
    r   = sum[ACC_W-1:FRAC_BITS];
    if (acc[ACC_W-1]) begin
      return '0;
    end else if (r > RW'(MaxCoord)) begin
      return MaxCoord;
    end
    return r[COORD_W-1:0];
  endfunction

  assign load      = !busy_q && !cmd_empty_i;
  assign cmd_pop_o = load;
  assign adv       = busy_q && (!out_valid_q || pop);
  assign last      = (k_q == steps_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
      end else if (adv && last) begin
        busy_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      accx_q  <= $signed(ACC_W'({cmd_i.xs, FRAC_BITS'(0)}));
      accy_q  <= $signed(ACC_W'({cmd_i.ys, FRAC_BITS'(0)}));
      incx_q  <= cmd_i.inc_x;
      incy_q  <= cmd_i.inc_y;
      steps_q <= cmd_i.steps;
      k_q     <= '0;
    end else if (adv) begin
      accx_q <= accx_q + ACC_W'(incx_q);
      accy_q <= accy_q + ACC_W'(incy_q);
      k_q    <= k_q + COORD_W'(1);
    end
    if (adv) begin
      out_q.pixel_x <= round_coord(accx_q);
      out_q.pixel_y <= round_coord(accy_q);
      out_q.last    <= last;
    end
  end

  assign pix_o = out_q;
  assign empty = !out_valid_q;

endmodule

// ===== rtl/core/dda_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// Line segment to pixel stream by the digital differential analyzer.
// ----------------------------------------------------------------------------
// A segment pushed in comes out as S+1 pixels, S being the larger absolute
// axis difference, the last one flagged and equal to the end point; a
// zero-length segment gives its start pixel alone. The front takes one
// segment at a time and runs the bit-serial divider on it twice, once per
// axis; a zero-length segment skips the divider. The back loads each
// segment from the queue, then emits one pixel per cycle while its output
// is empty or being popped. A two-entry queue between them lets both work
// at once.
module dda_line_rasterizer import dda_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  seg_t seg_i,
  input  logic push,
  output logic full,
  output pix_t pix_o,
  output logic empty,
  input  logic pop
);

  cmd_t f_cmd, q_cmd;
  logic f_push, q_full, q_empty, b_pop;

  dda_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .seg_i     (seg_i),
    .push      (push),
    .full      (full),
    .cmd_o     (f_cmd),
    .cmd_push_o(f_push),
    .cmd_full_i(q_full)
  );

  dda_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wdata_i(f_cmd),
    .push_i (f_push),
    .full_o (q_full),
    .rdata_o(q_cmd),
    .pop_i  (b_pop),
    .empty_o(q_empty)
  );

  dda_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (q_cmd),
    .cmd_empty_i(q_empty),
    .cmd_pop_o  (b_pop),
    .pix_o      (pix_o),
    .empty      (empty),
    .pop        (pop)
  );

endmodule
